// ===== hdl/btpc_pkg.sv =====
// shared types and constants for the barometer compensation block
`default_nettype none
package btpc_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_A123 = 3'd0;
	localparam logic [2:0] REG_A456 = 3'd1;
	localparam logic [2:0] REG_B12  = 3'd2;
	localparam logic [2:0] REG_MCMD = 3'd3;
	localparam logic [2:0] REG_OSS  = 3'd4;

	// datasheet constants
	localparam logic [31:0] C_B6_OFFSET = 32'd4000;
	localparam logic [31:0] C_B4_OFFSET = 32'd32768;
	localparam logic [31:0] C_B7_SCALE  = 32'd50000;
	localparam logic [31:0] C_P_KA      = 32'd3038;
	localparam logic [31:0] C_P_KB      = 32'hFFFF_E343;
	localparam logic [31:0] C_P_KC      = 32'd3791;
	// reciprocal of ten scaled by 2^35, exact for any 32-bit magnitude
	localparam logic [31:0] C_T_RECIP   = 32'hCCCC_CCCD;

	// datapath micro-steps
	typedef enum logic [4:0] {
		OP_T_M1, OP_T_X1, OP_T_DEN, OP_T_DIV, OP_T_B5, OP_T_T, OP_T_DIV2, OP_T_VAL,
		OP_P_B6, OP_P_M1, OP_P_SQ, OP_P_M2, OP_P_X1, OP_P_X3, OP_P_B3, OP_P_X3B,
		OP_P_M4, OP_P_B4, OP_P_B7, OP_P_DIV, OP_P_P, OP_P_M5, OP_P_M6, OP_P_M7,
		OP_P_FIN
	} op_t;

	typedef struct packed {
		logic load;
		logic exec;
		op_t  op;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic div_zero;
	} stat_t;

	typedef struct packed {
		logic [47:0] a123;
		logic [47:0] a456;
		logic [31:0] b12;
		logic [31:0] mcmd;
		logic [1:0]  oss;
	} coef_t;

endpackage
`default_nettype wire

// ===== hdl/baro_temp_pressure_compensation.sv =====
// top level of the barometer temperature and pressure compensation block
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  s_*     | in  | s_tvalid / s_tready | tdata: raw_reading[23:0]; tuser: mode
//  m_*     | out | m_tvalid / m_tready | tdata: value[31:0]; tuser: kind, divide_error
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_index selects register, cfg_data
//
// one item at a time; each item waits on the shared 32-step divider for one division,
// and its other datapath steps take one cycle per step, the tenth by reciprocal multiply
// a zero divisor skips the division and the steps after it: the item goes straight to
// the output register with divide_error set and a zero value
// the next item is taken the cycle after the result enters the output register; a stalled
// output holds one finished item and the next one waits for it before its own
// result is loaded
// reset clears the control state, the coefficients and the stored temperature base
// configuration writes are always taken; writes to indexes past the list are ignored
`default_nettype none
module baro_temp_pressure_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [23:0] raw_reading
	input  wire logic [0:0]  s_tuser,   // [0] mode
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] value
	output logic [1:0]       m_tuser,   // [0] kind, [1] divide_error
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);
	btpc_pkg::coef_t coef_q;
	btpc_pkg::cmd_t  cmd;
	btpc_pkg::stat_t stat;
	logic            out_kind, out_err;
	logic [31:0]     out_value;

	assign cfg_ready = 1'b1;

	// calibration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				btpc_pkg::REG_A123: coef_q.a123 <= cfg_data;
				btpc_pkg::REG_A456: coef_q.a456 <= cfg_data;
				btpc_pkg::REG_B12:  coef_q.b12  <= cfg_data[31:0];
				btpc_pkg::REG_MCMD: coef_q.mcmd <= cfg_data[31:0];
				btpc_pkg::REG_OSS:  coef_q.oss  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	btpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_mode   (s_tuser[0]),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// arithmetic and result register
	btpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.coef      (coef_q),
		.in_mode   (s_tuser[0]),
		.in_raw    (s_tdata),
		.out_kind  (out_kind),
		.out_value (out_value),
		.out_err   (out_err)
	);

	assign m_tdata = out_value;
	assign m_tuser = {out_err, out_kind};
endmodule
`default_nettype wire

// ===== hdl/btpc_div.sv =====
// iterative 32-step restoring divider, signed or unsigned
`default_nettype none
module btpc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        sgn,
	input  wire logic [31:0] dvd,
	input  wire logic [31:0] dvs,
	output logic             done,
	output logic [31:0]      quo
);
	logic        busy_q, done_q, neg_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [32:0] rem_sh;
	logic [33:0] diff;
	logic [31:0] dvd_abs, dvs_abs;

	assign dvd_abs = (sgn && dvd[31]) ? 32'(-dvd) : dvd;
	assign dvs_abs = (sgn && dvs[31]) ? 32'(-dvs) : dvs;
	assign rem_sh  = {rem_q, quo_q[31]};
	assign diff    = {1'b0, rem_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dvd_abs;
			dvs_q <= dvs_abs;
			neg_q <= sgn && (dvd[31] ^ dvs[31]);
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? 32'(-quo_q) : quo_q;
endmodule
`default_nettype wire

// ===== hdl/btpc_dp.sv =====
// compensation datapath: shared multiplier, working registers, divider, result register
`default_nettype none
module btpc_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire btpc_pkg::cmd_t cmd,
	output btpc_pkg::stat_t     stat,
	input  wire btpc_pkg::coef_t coef,
	input  wire logic           in_mode,
	input  wire logic [23:0]    in_raw,
	output logic                out_kind,
	output logic [31:0]         out_value,
	output logic                out_err
);
	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
		return 32'($signed(v) >>> n);
	endfunction

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] m_q, a_q, b6_q, sq_q, b3_q, d_q, b4_q, b7_q, p_q, up_q, base_q, val_q;
	logic [15:0] ut_q;
	logic        mode_q, err_q;
	logic        kind_o_q, err_o_q;
	logic [31:0] value_o_q;
	logic [31:0] mul_a, mul_b, ph, b3_sum, b3_shl, up_next;
	logic [63:0] mul_p;
	logic        mul_en, zero;
	logic        div_start, div_sgn, div_done;
	logic [31:0] div_dvd, div_dvs, div_q;
	logic [3:0]  up_shamt;

	assign ac1 = {{16{coef.a123[47]}}, coef.a123[47:32]};
	assign ac2 = {{16{coef.a123[31]}}, coef.a123[31:16]};
	assign ac3 = {{16{coef.a123[15]}}, coef.a123[15:0]};
	assign ac4 = {16'd0, coef.a456[47:32]};
	assign ac5 = {16'd0, coef.a456[31:16]};
	assign ac6 = {16'd0, coef.a456[15:0]};
	assign b1  = {{16{coef.b12[31]}}, coef.b12[31:16]};
	assign b2  = {{16{coef.b12[15]}}, coef.b12[15:0]};
	assign mc  = {{16{coef.mcmd[31]}}, coef.mcmd[31:16]};
	assign md  = {{16{coef.mcmd[15]}}, coef.mcmd[15:0]};

	assign up_shamt = 4'd8 - {2'b00, coef.oss};
	assign up_next  = {8'd0, in_raw} >> up_shamt;
	assign ph       = asr(p_q, 5'd8);
	assign b3_sum   = {ac1[29:0], 2'b00} + a_q;
	assign b3_shl   = b3_sum << coef.oss;
	assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};

	assign zero = ((cmd.op == btpc_pkg::OP_T_DIV) && (d_q == '0)) ||
	              ((cmd.op == btpc_pkg::OP_P_DIV) && (b4_q == '0));

	// multiplier operand selection
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (cmd.op)
			btpc_pkg::OP_T_M1: begin
				mul_a = {16'd0, ut_q} - ac6;
				mul_b = ac5;
			end
			btpc_pkg::OP_T_DIV2: begin
				mul_a = d_q[31] ? 32'(-d_q) : d_q;
				mul_b = btpc_pkg::C_T_RECIP;
			end
			btpc_pkg::OP_P_M1: begin
				mul_a = b6_q;
				mul_b = b6_q;
			end
			btpc_pkg::OP_P_M2: begin
				mul_a = b2;
				mul_b = sq_q;
			end
			btpc_pkg::OP_P_X1: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			btpc_pkg::OP_P_X3: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			btpc_pkg::OP_P_B3: begin
				mul_a = b1;
				mul_b = sq_q;
			end
			btpc_pkg::OP_P_M4: begin
				mul_a = ac4;
				mul_b = a_q;
			end
			btpc_pkg::OP_P_B4: begin
				mul_a = d_q;
				mul_b = btpc_pkg::C_B7_SCALE >> coef.oss;
			end
			btpc_pkg::OP_P_M5: begin
				mul_a = ph;
				mul_b = ph;
			end
			btpc_pkg::OP_P_M6: begin
				mul_a = m_q;
				mul_b = btpc_pkg::C_P_KA;
			end
			btpc_pkg::OP_P_M7: begin
				mul_a = p_q;
				mul_b = btpc_pkg::C_P_KB;
			end
			default: mul_en = 1'b0;
		endcase
	end

	// divider operand selection
	always_comb begin
		div_start = 1'b0;
		div_sgn   = 1'b1;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (cmd.op)
			btpc_pkg::OP_T_DIV: begin
				div_start = cmd.exec && !zero;
				div_dvd   = {mc[20:0], 11'd0};
				div_dvs   = d_q;
			end
			btpc_pkg::OP_P_DIV: begin
				div_start = cmd.exec && !zero;
				div_sgn   = 1'b0;
				div_dvd   = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
				div_dvs   = b4_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	btpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sgn    (div_sgn),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.done   (div_done),
		.quo    (div_q)
	);

	assign stat.div_done = div_done;
	assign stat.div_zero = zero;

	// stored compensation base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cmd.exec && (cmd.op == btpc_pkg::OP_T_B5)) begin
			base_q <= a_q + div_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			ut_q   <= in_raw[15:0];
			up_q   <= up_next;
			err_q  <= 1'b0;
			val_q  <= '0;
		end
		if (cmd.exec && mul_en) begin
			m_q <= mul_p[31:0];
		end
		if (cmd.exec) begin
			unique case (cmd.op)
				btpc_pkg::OP_T_X1:   a_q <= asr(m_q, 5'd15);
				btpc_pkg::OP_T_DEN:  d_q <= a_q + md;
				btpc_pkg::OP_T_DIV:  err_q <= zero;
				btpc_pkg::OP_T_T:    d_q <= asr(base_q + 32'd8, 5'd4);
				// magnitude over ten, sign put back in the next step
				btpc_pkg::OP_T_DIV2: a_q <= {3'd0, mul_p[63:35]};
				btpc_pkg::OP_T_VAL:  val_q <= d_q[31] ? 32'(-a_q) : a_q;
				btpc_pkg::OP_P_B6:   b6_q <= base_q - btpc_pkg::C_B6_OFFSET;
				btpc_pkg::OP_P_SQ:   sq_q <= asr(m_q, 5'd12);
				btpc_pkg::OP_P_X1:   a_q <= asr(m_q, 5'd11);
				btpc_pkg::OP_P_X3:   a_q <= a_q + asr(m_q, 5'd11);
				btpc_pkg::OP_P_B3: begin
					b3_q <= asr(b3_shl + 32'd2, 5'd2);
					a_q  <= asr(m_q, 5'd13);
				end
				btpc_pkg::OP_P_X3B:
					a_q <= asr(a_q + asr(m_q, 5'd16) + 32'd2, 5'd2) + btpc_pkg::C_B4_OFFSET;
				btpc_pkg::OP_P_M4:   d_q <= up_q - b3_q;
				btpc_pkg::OP_P_B4:   b4_q <= m_q >> 15;
				btpc_pkg::OP_P_B7:   b7_q <= m_q;
				btpc_pkg::OP_P_DIV:  err_q <= zero;
				btpc_pkg::OP_P_P:    p_q <= b7_q[31] ? {div_q[30:0], 1'b0} : div_q;
				btpc_pkg::OP_P_M7:   a_q <= asr(m_q, 5'd16);
				btpc_pkg::OP_P_FIN:
					val_q <= p_q + asr(a_q + asr(m_q, 5'd16) + btpc_pkg::C_P_KC, 5'd4);
				default: ;
			endcase
		end
		if (cmd.push) begin
			kind_o_q  <= mode_q;
			err_o_q   <= err_q;
			value_o_q <= err_q ? '0 : val_q;
		end
	end

	assign out_kind  = kind_o_q;
	assign out_err   = err_o_q;
	assign out_value = value_o_q;
endmodule
`default_nettype wire

// ===== hdl/btpc_ctrl.sv =====
// sequencer: steps the datapath through the temperature or pressure schedule
`default_nettype none
module btpc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_mode,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output btpc_pkg::cmd_t       cmd,
	input  wire btpc_pkg::stat_t stat
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_DIVW = 4'b0100,
		S_PUSH = 4'b1000
	} state_t;

	state_t          state_q;
	btpc_pkg::op_t   op_q;
	logic            out_valid_q;
	logic            accept, push, is_div, is_last;

	function automatic btpc_pkg::op_t next_op(input btpc_pkg::op_t op);
		btpc_pkg::op_t n;
		n = btpc_pkg::OP_T_M1;
		unique case (op)
			btpc_pkg::OP_T_M1:   n = btpc_pkg::OP_T_X1;
			btpc_pkg::OP_T_X1:   n = btpc_pkg::OP_T_DEN;
			btpc_pkg::OP_T_DEN:  n = btpc_pkg::OP_T_DIV;
			btpc_pkg::OP_T_DIV:  n = btpc_pkg::OP_T_B5;
			btpc_pkg::OP_T_B5:   n = btpc_pkg::OP_T_T;
			btpc_pkg::OP_T_T:    n = btpc_pkg::OP_T_DIV2;
			btpc_pkg::OP_T_DIV2: n = btpc_pkg::OP_T_VAL;
			btpc_pkg::OP_P_B6:   n = btpc_pkg::OP_P_M1;
			btpc_pkg::OP_P_M1:   n = btpc_pkg::OP_P_SQ;
			btpc_pkg::OP_P_SQ:   n = btpc_pkg::OP_P_M2;
			btpc_pkg::OP_P_M2:   n = btpc_pkg::OP_P_X1;
			btpc_pkg::OP_P_X1:   n = btpc_pkg::OP_P_X3;
			btpc_pkg::OP_P_X3:   n = btpc_pkg::OP_P_B3;
			btpc_pkg::OP_P_B3:   n = btpc_pkg::OP_P_X3B;
			btpc_pkg::OP_P_X3B:  n = btpc_pkg::OP_P_M4;
			btpc_pkg::OP_P_M4:   n = btpc_pkg::OP_P_B4;
			btpc_pkg::OP_P_B4:   n = btpc_pkg::OP_P_B7;
			btpc_pkg::OP_P_B7:   n = btpc_pkg::OP_P_DIV;
			btpc_pkg::OP_P_DIV:  n = btpc_pkg::OP_P_P;
			btpc_pkg::OP_P_P:    n = btpc_pkg::OP_P_M5;
			btpc_pkg::OP_P_M5:   n = btpc_pkg::OP_P_M6;
			btpc_pkg::OP_P_M6:   n = btpc_pkg::OP_P_M7;
			btpc_pkg::OP_P_M7:   n = btpc_pkg::OP_P_FIN;
			default:             n = btpc_pkg::OP_T_M1;
		endcase
		return n;
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign push     = (state_q == S_PUSH) && (!out_valid_q || out_ready);
	assign is_div   = (op_q == btpc_pkg::OP_T_DIV) || (op_q == btpc_pkg::OP_P_DIV);
	assign is_last  = (op_q == btpc_pkg::OP_T_VAL) || (op_q == btpc_pkg::OP_P_FIN);

	assign cmd.load = accept;
	assign cmd.exec = (state_q == S_RUN);
	assign cmd.op   = op_q;
	assign cmd.push = push;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= btpc_pkg::OP_T_M1;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
						op_q    <= in_mode ? btpc_pkg::OP_P_B6 : btpc_pkg::OP_T_M1;
					end
				end
				S_RUN: begin
					if (is_div) begin
						state_q <= stat.div_zero ? S_PUSH : S_DIVW;
					end else if (is_last) begin
						state_q <= S_PUSH;
					end else begin
						op_q <= next_op(op_q);
					end
				end
				S_DIVW: begin
					if (stat.div_done) begin
						state_q <= S_RUN;
						op_q    <= next_op(op_q);
					end
				end
				S_PUSH: begin
					if (push) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hdl/btpc_chk.sv =====
// port-level checks for the compensation block, bound to the top level
`default_nettype none
module btpc_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a divide error always reports a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
		else $error("divide error with nonzero value");

	// only one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");
endmodule

bind baro_temp_pressure_compensation btpc_chk u_btpc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
